// File: sv/bounded_list_store_core_assert.svh
// ----------------------------------------------------------------------------
// bounded_list_store_core_assert.svh
// Assertion macros shared by the list store RTL.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_LIST_STORE_CORE_ASSERT_SVH
`define BOUNDED_LIST_STORE_CORE_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define BLS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When ante holds, cons must hold in the same cycle.
`define BLS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// When ante holds, cons must hold in the next cycle.
`define BLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/bls_pkg.sv
// ----------------------------------------------------------------------------
// bls_pkg
// Types and fixed constants of the bounded list store.
// ----------------------------------------------------------------------------
package bls_pkg;

  localparam int CMD_W   = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 6;
  localparam int STAT_W  = 2;
  localparam int LEN_W   = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_END   = 3'd0,
    CMD_REM_LAST  = 3'd1,
    CMD_ADD_START = 3'd2,
    CMD_REM_FIRST = 3'd3,
    CMD_REM_AT    = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_SHIFT = 3'b100
  } state_t;

endpackage

// File: sv/bls_ram.sv
// ----------------------------------------------------------------------------
// bls_ram
// Entry store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bls_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [bls_pkg::VALUE_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic [bls_pkg::VALUE_W-1:0] rdata
);
  import bls_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: sv/bounded_list_store_core.sv
// ----------------------------------------------------------------------------
// bounded_list_store_core
// Ordered list of signed 32-bit values in a ring store of fixed capacity.
// ----------------------------------------------------------------------------
// A command item is accepted at a rising edge where start is high and busy
// is low; command, value and position are sampled there. Commands are add at
// end, remove last, add at start, remove first and remove at position.
// Every item yields exactly one result: removed_value, status and length are
// valid for the single cycle in which done is high. The receiver cannot stall,
// so a result is simply presented and taken at the end of that cycle.
// The entries live in a single synchronous RAM with one read and one write
// port. The read for a command is issued in the accept cycle, the result is
// formed in the execute state that follows and registered, so done is high in
// the cycle after the execute state. An item at the ends passes through the
// execute state only; busy is high until the block is back in idle, so no new
// item is taken before then. Remove at a nonzero position moves the entries
// behind it one slot forward through the RAM, one per cycle; busy stays high
// during the move.
// Reset clears the state, front pointer, entry count and done only; RAM
// contents are not cleared since no slot's data is used before it is written.
// ----------------------------------------------------------------------------
`include "bounded_list_store_core_assert.svh"

module bounded_list_store_core #(
  parameter int CAPACITY = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [bls_pkg::CMD_W-1:0]         command,
  input  logic signed [bls_pkg::VALUE_W-1:0] value,
  input  logic [bls_pkg::POS_W-1:0]         position,
  output logic                              done,
  output logic signed [bls_pkg::VALUE_W-1:0] removed_value,
  output logic [bls_pkg::STAT_W-1:0]        status,
  output logic [bls_pkg::LEN_W-1:0]         length
);
  import bls_pkg::*;

  // Pointer width, count width, and a common width for comparing position
  // against the count.
  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  // Ring slot that lies off places after base; off never exceeds CAPACITY
  // for any slot that is actually used.
  function automatic logic [PW-1:0] slot_at(logic [PW-1:0] base, logic [XW-1:0] off);
    logic [XW:0] s;
    s = (XW+1)'(base) + (XW+1)'(off);
    if (s >= (XW+1)'(CAPACITY)) begin
      s = s - (XW+1)'(CAPACITY);
    end
    return PW'(s);
  endfunction

  state_t             state, state_next;
  logic [PW-1:0]      front, front_next;
  logic [CW-1:0]      count, count_next;
  cmd_t               cmd_q, cmd_q_next;
  logic [VALUE_W-1:0] val_q, val_q_next;
  logic [POS_W-1:0]   pos_q, pos_q_next;
  logic [PW-1:0]      src, src_next;
  logic [PW-1:0]      dst, dst_next;
  logic [CW-1:0]      remaining, remaining_next;
  logic               done_next;
  logic [VALUE_W-1:0] removed_next;
  status_t            status_next;

  logic               mem_we;
  logic [PW-1:0]      mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic [PW-1:0]      mem_raddr;
  logic [VALUE_W-1:0] mem_rdata;

  logic               full;
  logic               empty;
  logic [XW-1:0]      pos_x;
  logic [XW-1:0]      count_x;
  logic [XW-1:0]      in_off;
  logic [CW-1:0]      moves;

  assign full    = (count == CW'(CAPACITY));
  assign empty   = (count == '0);
  assign pos_x   = XW'(pos_q);
  assign count_x = XW'(count);
  assign moves   = count - CW'(1) - CW'(pos_q);
  assign busy    = (state != S_IDLE);

  // Offset from the front of the entry a new command will read.
  always_comb begin
    case (cmd_t'(command))
      CMD_REM_LAST: in_off = XW'(count) - XW'(1);
      CMD_REM_AT:   in_off = XW'(position);
      default:      in_off = '0;
    endcase
  end

  bls_ram #(
    .DEPTH (CAPACITY),
    .AW    (PW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Accesses never overlap on one entry: a command's read is issued while
  // idle, after every write of the previous command has landed, and during a
  // move the write slot always trails the read slot by two.
  always_comb begin
    state_next     = state;
    front_next     = front;
    count_next     = count;
    cmd_q_next     = cmd_q;
    val_q_next     = val_q;
    pos_q_next     = pos_q;
    src_next       = src;
    dst_next       = dst;
    remaining_next = remaining;
    done_next      = 1'b0;
    removed_next   = '0;
    status_next    = ST_OK;
    mem_we         = 1'b0;
    mem_waddr      = dst;
    mem_wdata      = val_q;
    mem_raddr      = slot_at(front, in_off);

    case (state)
      S_IDLE: begin
        if (start) begin
          cmd_q_next = cmd_t'(command);
          val_q_next = value;
          pos_q_next = position;
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        done_next  = 1'b1;
        state_next = S_IDLE;
        case (cmd_q)
          CMD_ADD_END: begin
            if (full) begin
              status_next = ST_FULL;
            end else begin
              mem_we     = 1'b1;
              mem_waddr  = slot_at(front, count_x);
              count_next = count + CW'(1);
            end
          end
          CMD_ADD_START: begin
            if (full) begin
              status_next = ST_FULL;
            end else begin
              front_next = slot_at(front, XW'(CAPACITY - 1));
              mem_we     = 1'b1;
              mem_waddr  = front_next;
              count_next = count + CW'(1);
            end
          end
          CMD_REM_LAST: begin
            if (empty) begin
              status_next = ST_EMPTY;
            end else begin
              removed_next = mem_rdata;
              count_next   = count - CW'(1);
            end
          end
          CMD_REM_FIRST: begin
            if (empty) begin
              status_next = ST_EMPTY;
            end else begin
              removed_next = mem_rdata;
              front_next   = slot_at(front, XW'(1));
              count_next   = count - CW'(1);
            end
          end
          CMD_REM_AT: begin
            if (empty) begin
              status_next = ST_EMPTY;
            end else if (pos_x >= count_x) begin
              status_next = ST_RANGE;
            end else if (pos_q == '0) begin
              removed_next = mem_rdata;
              front_next   = slot_at(front, XW'(1));
              count_next   = count - CW'(1);
            end else begin
              removed_next = mem_rdata;
              count_next   = count - CW'(1);
              if (moves != '0) begin
                // Start closing the gap: read the entry behind the hole.
                src_next       = slot_at(front, pos_x + XW'(1));
                dst_next       = slot_at(front, pos_x);
                mem_raddr      = src_next;
                remaining_next = moves;
                state_next     = S_SHIFT;
              end
            end
          end
          default: begin
          end
        endcase
      end

      S_SHIFT: begin
        mem_we         = 1'b1;
        mem_waddr      = dst;
        mem_wdata      = mem_rdata;
        dst_next       = src;
        src_next       = slot_at(src, XW'(1));
        mem_raddr      = src_next;
        remaining_next = remaining - CW'(1);
        if (remaining == CW'(1)) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_q         <= cmd_q_next;
    val_q         <= val_q_next;
    pos_q         <= pos_q_next;
    src           <= src_next;
    dst           <= dst_next;
    remaining     <= remaining_next;
    removed_value <= removed_next;
    status        <= status_next;
    length        <= LEN_W'(count_next);
  end

  `BLS_ASSERT_ALWAYS(a_count_bound, count <= CW'(CAPACITY), "entry count exceeds capacity")
  `BLS_ASSERT_NEXT(a_accept_exec, start && !busy, state == S_EXEC, "accepted item not executed")
  `BLS_ASSERT_NEXT(a_exec_done, state == S_EXEC, done, "no result after execute cycle")
  `BLS_ASSERT_IMPL(a_done_length, done, length == LEN_W'(count), "length disagrees with count")
  `BLS_ASSERT_IMPL(a_shift_left, state == S_SHIFT, remaining != '0, "move with nothing left")

endmodule

// File: tb/tb_bounded_list_store_core.sv
// ----------------------------------------------------------------------------
// tb_bounded_list_store_core
// Self-checking testbench for the bounded list store core.
// ----------------------------------------------------------------------------
// A directed table covers the empty, single-element and out-of-range cases first.
// Random traffic then follows, in fill, drain and mixed runs, so that the list
// reaches both empty and full many times. A behavioral copy of the list
// predicts the result of every accepted item. Each result is compared with the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_bounded_list_store_core;
  timeunit 1ns;
  timeprecision 1ps;

  import bls_pkg::*;

  localparam int LIST_DEPTH   = 64;
  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 4;
  localparam int RANDOM_ITEMS = 850;
  localparam int DRAIN_EVERY  = 150;
  localparam int MAX_REPORTS  = 10;
  // The longest item is a remove at position 1 of a full list, which shifts
  // nearly every entry. The tail and the stall limit cover that.
  localparam int TAIL_CYCLES  = LIST_DEPTH + 8;
  localparam int STALL_LIMIT  = 2000;

  // Command codes that the block must ignore.
  localparam logic [CMD_W-1:0] CMD_UNDEF_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNDEF_LAST  = 3'd7;

  typedef struct packed {
    logic signed [VALUE_W-1:0] removed;
    status_t                   status;
    logic [LEN_W-1:0]          len;
  } list_result_t;

  typedef struct {
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] val;
    logic [POS_W-1:0]          pos;
    bit                        listed;
    list_result_t              outcome;
  } directed_row_t;

  typedef enum {FILL_RUN, DRAIN_RUN, MIXED_RUN} traffic_mode_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic [CMD_W-1:0]          command = '0;
  logic signed [VALUE_W-1:0] value = '0;
  logic [POS_W-1:0]          position = '0;
  logic                      busy;
  logic                      done;
  logic signed [VALUE_W-1:0] removed_value;
  logic [STAT_W-1:0]         status;
  logic [LEN_W-1:0]          length;

  // Behavioral copy of the list: ring store, front slot and entry count.
  logic signed [VALUE_W-1:0] slot_data [LIST_DEPTH];
  int                        head_slot = 0;
  int                        held_count = 0;

  // Predicted results in the order their items were accepted.
  list_result_t pending_results[$];
  list_result_t oldest_expected;
  int           error_count = 0;
  int           stalled_cycles = 0;

  logic [CMD_W-1:0] add_codes [2] = '{CMD_ADD_END, CMD_ADD_START};
  logic [CMD_W-1:0] removal_codes [3] = '{CMD_REM_LAST, CMD_REM_FIRST, CMD_REM_AT};
  logic signed [VALUE_W-1:0] value_extremes [4] =
    '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1};

  // Directed items. Rows marked listed carry a result that is plain from the
  // command alone: empty-list errors, out-of-range errors, ignored codes and
  // adding and removing a single extreme value. The remaining rows use the prediction.
  directed_row_t stimulus_table [25] = '{
    // Every removal on an empty list reports empty.
    '{CMD_REM_LAST,    32'sd0,          6'd0,  1'b1, '{32'sd0, ST_EMPTY, 7'd0}},
    '{CMD_REM_FIRST,   32'sd0,          6'd0,  1'b1, '{32'sd0, ST_EMPTY, 7'd0}},
    '{CMD_REM_AT,      32'sd0,          6'd0,  1'b1, '{32'sd0, ST_EMPTY, 7'd0}},
    '{CMD_REM_AT,      32'sd0,          6'd63, 1'b1, '{32'sd0, ST_EMPTY, 7'd0}},
    '{CMD_UNDEF_FIRST, 32'sh1234_5678,  6'd63, 1'b1, '{32'sd0, ST_OK,    7'd0}},
    // Single element added and removed at each end and through index zero.
    '{CMD_ADD_END,     32'sh7FFF_FFFF,  6'd0,  1'b1, '{32'sd0, ST_OK,    7'd1}},
    '{CMD_REM_LAST,    32'sd0,          6'd0,  1'b1, '{32'sh7FFF_FFFF, ST_OK, 7'd0}},
    '{CMD_ADD_START,   32'sh8000_0000,  6'd0,  1'b1, '{32'sd0, ST_OK,    7'd1}},
    '{CMD_REM_FIRST,   32'sd0,          6'd0,  1'b1, '{32'sh8000_0000, ST_OK, 7'd0}},
    '{CMD_ADD_START,   -32'sd1,         6'd0,  1'b1, '{32'sd0, ST_OK,    7'd1}},
    '{CMD_REM_AT,      32'sd0,          6'd0,  1'b1, '{-32'sd1, ST_OK,   7'd0}},
    // Build a short list, then probe the index range.
    '{CMD_ADD_END,     32'sd1,          6'd0,  1'b0, '{32'sd0, ST_OK,    7'd0}},
    '{CMD_ADD_END,     32'sd2,          6'd0,  1'b0, '{32'sd0, ST_OK,    7'd0}},
    '{CMD_ADD_START,   32'sd3,          6'd0,  1'b0, '{32'sd0, ST_OK,    7'd0}},
    '{CMD_ADD_END,     32'sh5555_5555,  6'd0,  1'b0, '{32'sd0, ST_OK,    7'd0}},
    '{CMD_REM_AT,      32'sd0,          6'd4,  1'b1, '{32'sd0, ST_RANGE, 7'd4}},
    '{CMD_REM_AT,      32'sd0,          6'd63, 1'b1, '{32'sd0, ST_RANGE, 7'd4}},
    '{CMD_UNDEF_LAST,  -32'sd1,         6'd0,  1'b1, '{32'sd0, ST_OK,    7'd4}},
    // Middle removal, index zero with a longer list, then the last by index.
    '{CMD_REM_AT,      32'sd0,          6'd1,  1'b0, '{32'sd0, ST_OK,    7'd0}},
    '{CMD_REM_AT,      32'sd0,          6'd0,  1'b0, '{32'sd0, ST_OK,    7'd0}},
    '{CMD_REM_AT,      32'sd0,          6'd1,  1'b0, '{32'sd0, ST_OK,    7'd0}},
    '{CMD_UNDEF_FIRST, 32'shAAAA_AAAA,  6'd1,  1'b0, '{32'sd0, ST_OK,    7'd0}},
    '{CMD_REM_LAST,    32'sd0,          6'd0,  1'b0, '{32'sd0, ST_OK,    7'd0}},
    '{CMD_ADD_START,   32'shAAAA_AAAA,  6'd0,  1'b0, '{32'sd0, ST_OK,    7'd0}},
    '{CMD_REM_LAST,    32'sd0,          6'd0,  1'b0, '{32'sd0, ST_OK,    7'd0}}
  };

  bounded_list_store_core #(
    .CAPACITY(LIST_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .value(value),
    .position(position),
    .done(done),
    .removed_value(removed_value),
    .status(status),
    .length(length)
  );

  always #CLK_HALF clk = ~clk;

  // Ring slot that lies off places after slot base.
  function automatic int ring_slot(int base, int off);
    return (base + off) % LIST_DEPTH;
  endfunction

  // Applies one command to the behavioral list and returns its result.
  function automatic list_result_t predict_list_command(logic [CMD_W-1:0] cmd,
                                                        logic signed [VALUE_W-1:0] val,
                                                        logic [POS_W-1:0] pos);
    list_result_t r;
    int           idx;
    r.removed = '0;
    r.status  = ST_OK;
    case (cmd)
      CMD_ADD_END: begin
        if (held_count >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slot_data[ring_slot(head_slot, held_count)] = val;
          held_count++;
        end
      end
      CMD_ADD_START: begin
        if (held_count >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          head_slot = ring_slot(head_slot, LIST_DEPTH - 1);
          slot_data[head_slot] = val;
          held_count++;
        end
      end
      CMD_REM_LAST: begin
        if (held_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.removed = slot_data[ring_slot(head_slot, held_count - 1)];
          held_count--;
        end
      end
      CMD_REM_FIRST: begin
        if (held_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.removed = slot_data[head_slot];
          head_slot = ring_slot(head_slot, 1);
          held_count--;
        end
      end
      CMD_REM_AT: begin
        if (held_count == 0) begin
          r.status = ST_EMPTY;
        end else if (int'(pos) >= held_count) begin
          r.status = ST_RANGE;
        end else if (pos == 0) begin
          r.removed = slot_data[head_slot];
          head_slot = ring_slot(head_slot, 1);
          held_count--;
        end else begin
          r.removed = slot_data[ring_slot(head_slot, int'(pos))];
          for (idx = int'(pos); idx + 1 < held_count; idx++) begin
            slot_data[ring_slot(head_slot, idx)] = slot_data[ring_slot(head_slot, idx + 1)];
          end
          held_count--;
        end
      end
      default: begin
      end
    endcase
    r.len = held_count[LEN_W-1:0];
    return r;
  endfunction

  task automatic note_failure(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
  endtask

  // Presents one item and holds it until the block takes it. Called at a
  // rising edge; returns at the edge that accepted the item, with start still
  // high so that a following item can go out back to back.
  task automatic issue_list_command(input logic [CMD_W-1:0] c,
                                    input logic signed [VALUE_W-1:0] v,
                                    input logic [POS_W-1:0] p,
                                    input bit use_listed,
                                    input list_result_t listed);
    list_result_t predicted;
    start    <= 1'b1;
    command  <= c;
    value    <= v;
    position <= p;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = predict_list_command(c, v, p);
    pending_results.push_back(use_listed ? listed : predicted);
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Holds the sender off until every outstanding result has come back.
  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Result checker. The block cannot be stalled, so every cycle with done
  // high carries one result that must match the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("result with no item outstanding: removed=%0d status=%0d len=%0d",
                               removed_value, status, length));
      end else begin
        oldest_expected = pending_results.pop_front();
        if (removed_value !== oldest_expected.removed || status !== oldest_expected.status ||
            length !== oldest_expected.len) begin
          note_failure($sformatf("exp removed=%0d status=%0d len=%0d, got removed=%0d status=%0d len=%0d",
                                 oldest_expected.removed, oldest_expected.status,
                                 oldest_expected.len, removed_value, status, length));
        end
      end
    end
  end

  // Watchdog: ends the run when neither an item nor a result has moved for
  // far longer than the slowest command can take.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
    if (stalled_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    traffic_mode_t             mode;
    int                        mode_left;
    int                        burst_left;
    int                        listed_items;
    int                        since_drain;
    int                        roll;
    logic [CMD_W-1:0]          c;
    logic signed [VALUE_W-1:0] v;
    logic [POS_W-1:0]          p;
    list_result_t              no_listing;

    no_listing.removed = '0;
    no_listing.status  = ST_OK;
    no_listing.len     = '0;
    mode         = MIXED_RUN;
    mode_left    = 0;
    burst_left   = 0;
    listed_items = 0;
    since_drain  = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, sent back to back.
    foreach (stimulus_table[i]) begin
      issue_list_command(stimulus_table[i].cmd, stimulus_table[i].val, stimulus_table[i].pos,
                         stimulus_table[i].listed, stimulus_table[i].outcome);
    end
    wait_for_results();

    // Random part. Fill runs mostly add, so the list reaches full and the
    // full status shows up; drain runs mostly remove, so it empties again.
    // Mixed runs spread over all commands. A few ignored codes are mixed in
    // everywhere but do not count toward the item total.
    while (listed_items < RANDOM_ITEMS) begin
      if (mode_left == 0) begin
        mode      = traffic_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(30, 150);
      end
      // Items go out in bursts. Between bursts the sender either idles for a
      // random time, goes straight on, or now and then waits for the block
      // to deliver everything it owes.
      if (burst_left == 0) begin
        if (since_drain >= DRAIN_EVERY) begin
          wait_for_results();
          since_drain = 0;
        end else if ($urandom_range(0, 9) < 7) begin
          pause_sender($urandom_range(1, 12));
        end
        burst_left = $urandom_range(1, 24);
      end

      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        c = CMD_W'($urandom_range(CMD_UNDEF_FIRST, CMD_UNDEF_LAST));
      end else begin
        case (mode)
          FILL_RUN:  c = (roll < 88) ? add_codes[$urandom_range(0, 1)]
                                     : removal_codes[$urandom_range(0, 2)];
          DRAIN_RUN: c = (roll < 88) ? removal_codes[$urandom_range(0, 2)]
                                     : add_codes[$urandom_range(0, 1)];
          default:   c = CMD_W'($urandom_range(CMD_ADD_END, CMD_REM_AT));
        endcase
      end

      if ($urandom_range(0, 9) == 0) begin
        v = value_extremes[$urandom_range(0, 3)];
      end else begin
        v = $urandom;
      end

      // Positions favor the valid range, its last index and index zero, with
      // a share of fully random ones to hit the out-of-range case.
      roll = $urandom_range(0, 9);
      if (held_count > 0 && roll < 5) begin
        p = POS_W'($urandom_range(0, held_count - 1));
      end else if (held_count > 0 && roll < 7) begin
        p = POS_W'(held_count - 1);
      end else if (roll < 8) begin
        p = '0;
      end else begin
        p = POS_W'($urandom_range(0, LIST_DEPTH - 1));
      end

      issue_list_command(c, v, p, 1'b0, no_listing);
      if (c <= CMD_REM_AT) begin
        listed_items++;
      end
      mode_left--;
      burst_left--;
      since_drain++;
    end

    // Let every result come back, then allow time for anything stray.
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
